// ===== src/wlan_activity_led_blinker_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the WLAN activity LED blinker.
// Small wrappers around concurrent assertions, so that each check is one line.
// ----------------------------------------------------------------------------
`ifndef WLAN_ACTIVITY_LED_BLINKER_MACROS_SVH
`define WLAN_ACTIVITY_LED_BLINKER_MACROS_SVH

// Next-cycle implication, ignored while reset is high.
`define WLB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("WLAN LED blinker check failed");

// Next-cycle implication that is also checked across reset.
`define WLB_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("WLAN LED blinker check failed");

`endif

// ===== src/wlb_pkg.sv =====
// ----------------------------------------------------------------------------
// wlb_pkg
// Beat types and fixed constants shared by the WLAN activity LED blinker.
// ----------------------------------------------------------------------------
`default_nettype none

package wlb_pkg;

   // One tick of link status. The first member is the most significant bit.
   typedef struct packed {
      logic link_up;
      logic asleep;
      logic scanning;
      logic reconnecting;
      logic radio_off;
      logic high_band;
      logic traffic_seen;
      logic alpha_start;
   } wlb_req_type;

   typedef struct packed {
      logic led_a_on;
      logic led_b_on;
   } wlb_rsp_type;

   // Register indexes on the write port.
   localparam logic [1:0] CSR_LED_STYLE    = 2'd0;
   localparam logic [1:0] CSR_MODE_WORD_A  = 2'd1;
   localparam logic [1:0] CSR_MODE_WORD_B  = 2'd2;
   localparam logic [1:0] CSR_BAND_SUPPORT = 2'd3;

   localparam int unsigned CSR_DATA_W = 16;

   // Style codes; any other value selects the mode-word style.
   localparam logic [1:0] STYLE_BAND  = 2'd2;
   localparam logic [1:0] STYLE_DUTY  = 2'd3;
   localparam logic [1:0] STYLE_RESET = 2'd1;
   localparam logic [1:0] BAND_RESET  = 2'b11;

   // Mode word bit positions.
   localparam int unsigned MODE_SLEEP_KEEP = 3;
   localparam int unsigned MODE_POLARITY   = 4;
   localparam int unsigned MODE_ACTIVITY   = 5;
   localparam int unsigned MODE_SLOW       = 6;

   // Alpha pattern ends once the count has passed this value.
   localparam logic [5:0] ALPHA_LAST      = 6'd34;
   localparam logic [1:0] ALPHA_PHASE_OFF = 2'd2;

   // Band scan: phase within a 16-tick frame that shows the 5 GHz result.
   localparam logic [3:0] BAND_PHASE_HIGH = 4'd8;

   // Duty style on times within an 8-tick frame.
   localparam logic [2:0] DUTY_ON_LINKED = 3'd6;
   localparam logic [2:0] DUTY_ON_SEARCH = 3'd2;

   // Base slow-blink half period in ticks.
   localparam logic [6:0] SLOW_BASE = 7'd5;

endpackage

`default_nettype wire

// ===== src/wlan_activity_led_blinker.sv =====
// ----------------------------------------------------------------------------
// wlan_activity_led_blinker
// Two-LED WLAN status blinker advanced by one link status beat per tick.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake          Contents
//   req_      in          valid / ready      link status flags of one tick
//   rsp_      out         valid / ready      both LED levels after the tick
//   csr_      in          write enable only  style, mode words, band support
//
// A tick in the alpha pattern, the band style or the duty style goes through
// the accept state and then the result state, which updates the LEDs and loads
// the result register. A tick in the mode-word style goes through the accept
// state, two passes over the 32 counter bits in the bit-serial remainder unit
// (one pass per LED, one counter bit per cycle) and then the result state.
// Reset is synchronous and clears the control state at once, but not the
// payload registers; there is no clearing pass. The next beat is taken as
// soon as the result register is loaded. If the previous result has not been
// taken by then, the block waits in its result state until it has.
//
`default_nettype none

module wlan_activity_led_blinker (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   input  wire wlb_pkg::wlb_req_type req_data,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   output      wlb_pkg::wlb_rsp_type rsp_data,
   input  wire logic                 csr_we,
   input  wire logic [1:0]           csr_index,
   input  wire logic [wlb_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import wlb_pkg::*;

   // Sequencer states.
   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_LED_A  = 2'd1;
   localparam logic [1:0] S_LED_B  = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [31:0] tick_ff, tick_in;
   wlb_req_type flags_ff, flags_in;
   logic        traffic_ff, traffic_in;
   logic        alpha_ff, alpha_in;
   logic [5:0]  alpha_count_ff, alpha_count_in;
   logic [1:0]  alpha_phase_ff, alpha_phase_in;
   logic [1:0]  led_ff, led_in;
   logic [4:0]  bit_ff, bit_in;
   logic [7:0]  rem_ff, rem_in;
   logic [1:0]  style_ff, style_in;
   logic [15:0] mode_a_ff, mode_a_in;
   logic [15:0] mode_b_ff, mode_b_in;
   logic [1:0]  band_ff, band_in;
   logic        rsp_valid_ff, rsp_valid_in;
   wlb_rsp_type rsp_data_ff, rsp_data_in;

   // Mode-word decode for the LED that the remainder unit is working on.
   logic        led_idx;
   logic [15:0] cur_mode;
   logic [4:0]  time_sum;
   logic [6:0]  on_ticks;
   logic [7:0]  div_unlinked;
   logic [6:0]  slow_period;
   logic [7:0]  divisor;

   // Remainder unit: one restoring step per cycle.
   logic [8:0]  rem_shift;
   logic [7:0]  rem_step;

   // Band and duty style helpers.
   logic        scan_wanted;
   logic        band_hit;
   logic        band_lit_a;
   logic        band_op;
   logic [15:0] band_mode;
   logic        duty_on;
   logic        alpha_end;
   logic [5:0]  alpha_cnt_use;
   logic [1:0]  alpha_ph_use;
   logic        slow_first;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      led_idx      = (state_ff == S_LED_B);
      cur_mode     = led_idx ? mode_b_ff : mode_a_ff;
      // On and off times count in units of five ticks.
      time_sum     = 5'(cur_mode[11:8]) + 5'(cur_mode[15:12]);
      on_ticks     = 7'({cur_mode[11:8], 2'b00}) + 7'(cur_mode[11:8]);
      div_unlinked = 8'({time_sum, 2'b00}) + 8'(time_sum);
      slow_period  = SLOW_BASE << cur_mode[5:4];
      divisor      = flags_ff.link_up ? {slow_period, 1'b0} : div_unlinked;

      rem_shift = {rem_ff, tick_ff[bit_ff]};
      if (rem_shift >= {1'b0, divisor}) begin
         rem_step = 8'(rem_shift - {1'b0, divisor});
      end else begin
         rem_step = rem_shift[7:0];
      end
      slow_first = (rem_step < {1'b0, slow_period});
   end

   always_comb begin
      scan_wanted = (flags_ff.radio_off && flags_ff.scanning) ||
                    (!flags_ff.radio_off && flags_ff.reconnecting);
      band_hit    = (tick_ff[3:0] == 4'd0) || (tick_ff[3:0] == BAND_PHASE_HIGH);
      band_lit_a  = (tick_ff[3:0] == 4'd0) ? band_ff[0] : !band_ff[1];
      band_op     = flags_ff.high_band;
      band_mode   = band_op ? mode_b_ff : mode_a_ff;
      duty_on     = (tick_ff[2:0] <
                     (flags_ff.link_up ? DUTY_ON_LINKED : DUTY_ON_SEARCH));
      alpha_end   = (alpha_count_ff > ALPHA_LAST);
      alpha_cnt_use = alpha_end ? 6'd0 : alpha_count_ff;
      alpha_ph_use  = alpha_end ? 2'd0 : alpha_phase_ff;
   end

   always_comb begin
      state_in       = state_ff;
      tick_in        = tick_ff;
      flags_in       = flags_ff;
      traffic_in     = traffic_ff;
      alpha_in       = alpha_ff;
      alpha_count_in = alpha_count_ff;
      alpha_phase_in = alpha_phase_ff;
      led_in         = led_ff;
      bit_in         = bit_ff;
      rem_in         = rem_ff;
      style_in       = style_ff;
      mode_a_in      = mode_a_ff;
      mode_b_in      = mode_b_ff;
      band_in        = band_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_LED_STYLE:    style_in  = csr_wdata[1:0];
            CSR_MODE_WORD_A:  mode_a_in = csr_wdata;
            CSR_MODE_WORD_B:  mode_b_in = csr_wdata;
            CSR_BAND_SUPPORT: band_in   = csr_wdata[1:0];
            default:          style_in  = style_ff;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               // Latch the request flags and advance the tick counter together.
               tick_in  = tick_ff + 32'd1;
               flags_in = req_data;
               if (req_data.traffic_seen) begin
                  traffic_in = 1'b1;
               end
               if (req_data.alpha_start) begin
                  alpha_in = 1'b1;
               end
               bit_in = 5'd31;
               rem_in = 8'd0;
               if (!(alpha_ff || req_data.alpha_start) &&
                   (style_ff != STYLE_BAND) && (style_ff != STYLE_DUTY)) begin
                  state_in = S_LED_A;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end

         S_LED_A, S_LED_B: begin
            rem_in = rem_step;
            bit_in = bit_ff - 5'd1;
            if (bit_ff == 5'd0) begin
               // Remainder complete: resolve this LED of the mode-word style.
               if (!flags_ff.link_up) begin
                  if (time_sum != 5'd0) begin
                     led_in[led_idx] = (rem_step < {1'b0, on_ticks});
                  end
               end else if (flags_ff.asleep && !cur_mode[MODE_SLEEP_KEEP]) begin
                  led_in[led_idx] = 1'b0;
               end else if (!cur_mode[MODE_SLOW]) begin
                  if (!tick_ff[0]) begin
                     led_in[led_idx] = cur_mode[MODE_POLARITY];
                  end else if (traffic_ff) begin
                     traffic_in = 1'b0;
                     if (cur_mode[MODE_ACTIVITY]) begin
                        led_in[led_idx] = !cur_mode[MODE_POLARITY];
                     end
                  end
               end else begin
                  if (!tick_ff[0]) begin
                     led_in[led_idx] = !slow_first;
                  end else if (traffic_ff) begin
                     traffic_in      = 1'b0;
                     led_in[led_idx] = slow_first;
                  end
               end
               rem_in   = 8'd0;
               bit_in   = 5'd31;
               state_in = led_idx ? S_FINISH : S_LED_B;
            end
         end

         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               if (alpha_ff) begin
                  if (alpha_end) begin
                     alpha_in = 1'b0;
                  end
                  led_in[0]      = (alpha_ph_use != ALPHA_PHASE_OFF);
                  alpha_count_in = alpha_cnt_use + 6'd1;
                  alpha_phase_in = (alpha_ph_use == ALPHA_PHASE_OFF) ?
                                   2'd0 : alpha_ph_use + 2'd1;
               end else if (style_ff == STYLE_BAND) begin
                  if (!flags_ff.link_up) begin
                     if (tick_ff[1:0] == 2'd0) begin
                        if (scan_wanted && band_hit) begin
                           led_in = {!band_lit_a, band_lit_a};
                        end else begin
                           led_in = 2'b00;
                        end
                     end
                  end else if (flags_ff.scanning) begin
                     if (tick_ff[1:0] == 2'd0) begin
                        led_in = band_hit ? {!band_lit_a, band_lit_a} : 2'b00;
                     end
                  end else begin
                     led_in[!band_op] = 1'b0;
                     if (flags_ff.asleep && !band_mode[MODE_SLEEP_KEEP]) begin
                        led_in[band_op] = 1'b0;
                     end else if (!tick_ff[0]) begin
                        led_in[band_op] = 1'b1;
                     end else if (traffic_ff) begin
                        traffic_in      = 1'b0;
                        led_in[band_op] = 1'b0;
                     end
                  end
               end else if (style_ff == STYLE_DUTY) begin
                  if (!flags_ff.link_up) begin
                     if (!tick_ff[0]) begin
                        led_in = (scan_wanted && duty_on) ? 2'b11 : 2'b00;
                     end
                  end else if (flags_ff.scanning) begin
                     if (!tick_ff[0]) begin
                        led_in = duty_on ? 2'b11 : 2'b00;
                     end
                  end else if (flags_ff.asleep && !mode_a_ff[MODE_SLEEP_KEEP]) begin
                     led_in = 2'b00;
                  end else if (!tick_ff[0]) begin
                     led_in = 2'b11;
                  end else if (traffic_ff) begin
                     traffic_in = 1'b0;
                     led_in     = 2'b00;
                  end
               end
               rsp_valid_in         = 1'b1;
               rsp_data_in.led_a_on = led_in[0];
               rsp_data_in.led_b_on = led_in[1];
               state_in             = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         tick_ff        <= 32'd0;
         traffic_ff     <= 1'b0;
         alpha_ff       <= 1'b0;
         alpha_count_ff <= 6'd0;
         alpha_phase_ff <= 2'd0;
         led_ff         <= 2'b00;
         style_ff       <= STYLE_RESET;
         mode_a_ff      <= 16'd0;
         mode_b_ff      <= 16'd0;
         band_ff        <= BAND_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         tick_ff        <= tick_in;
         traffic_ff     <= traffic_in;
         alpha_ff       <= alpha_in;
         alpha_count_ff <= alpha_count_in;
         alpha_phase_ff <= alpha_phase_in;
         led_ff         <= led_in;
         style_ff       <= style_in;
         mode_a_ff      <= mode_a_in;
         mode_b_ff      <= mode_b_in;
         band_ff        <= band_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      flags_ff    <= flags_in;
      bit_ff      <= bit_in;
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

// ===== src/wlb_checker.sv =====
// ----------------------------------------------------------------------------
// wlb_checker
// Port-level checks for the WLAN activity LED blinker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "wlan_activity_led_blinker_macros.svh"

module wlb_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire wlb_pkg::wlb_rsp_type rsp_data
);

   // A tick is still being worked on in the cycle after it is taken.
   `WLB_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // A waiting result beat stays in place until it is taken.
   `WLB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // Reset leaves no result pending.
   `WLB_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

endmodule

bind wlan_activity_led_blinker wlb_checker u_wlb_checker (.*);

`default_nettype wire
